/* rtl/mtfa_pkg.sv */
`default_nettype none

package mtfa_pkg;

	// Field widths.
	localparam int FREQ_W  = 20;
	localparam int POWER_W = 32;
	localparam int OUT_W   = 48;
	localparam int ACC_W   = 48;
	localparam int WIDE_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

	// Configuration port.
	localparam int CFG_IDX_W = 2;

	// Slope reciprocal floor(2^32 / width) needs 33 bits.
	localparam int RECIP_W    = 33;
	localparam int DIV_STEPS  = RECIP_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Weight is Q1.16 in the range 0..65536.
	localparam int WEIGHT_W   = 17;
	localparam int FRAC_W     = 16;
	localparam int WPROD_W    = FREQ_W + RECIP_W;
	localparam int WRAW_W     = WPROD_W - FRAC_W;
	localparam int PFULL_W    = WEIGHT_W + POWER_W;
	localparam int PPROD_W    = PFULL_W - FRAC_W;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
	localparam logic [FREQ_W-1:0]   ONE_HZ     = FREQ_W'(16);
	localparam logic [RECIP_W-1:0]  RECIP_RST  = RECIP_W'(64'd1 << 28);
	localparam logic [OUT_W-1:0]    OUT_MAX    = '1;

	// Queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW    = 2'd0,
		REG_CENTER = 2'd1,
		REG_HIGH   = 2'd2
	} cfg_reg_t;

	// Reciprocal sequencer states.
	typedef enum logic [1:0] {
		FS_IDLE,
		FS_RISE,
		FS_FALL
	} front_state_t;

	// Divider request and response.
	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] width;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RECIP_W-1:0] quotient;
	} div_rsp_t;

	// Classified bin carried through the queue.
	typedef struct packed {
		logic [FREQ_W-1:0]  diff;
		logic [RECIP_W-1:0] recip;
		logic [POWER_W-1:0] power;
		logic               last;
	} item_t;

endpackage

`default_nettype wire

/* rtl/mtfa_recip_div.sv */
`default_nettype none

// Restoring divider for floor(2^32 / width), one quotient bit per cycle.
module mtfa_recip_div
	import mtfa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FREQ_W-1:0]    width_q;
	logic [FREQ_W-1:0]    rem_q;
	logic [RECIP_W-1:0]   quo_q;

	logic                 num_bit;
	logic [FREQ_W:0]      shifted;
	logic                 ge;
	logic [FREQ_W:0]      diff;

	// The dividend is 2^32: only its top bit is set.
	always_comb begin
		num_bit = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		shifted = {rem_q, num_bit};
		ge      = (shifted >= {1'b0, width_q});
		diff    = shifted - {1'b0, width_q};
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			width_q <= req.width;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
			quo_q <= {quo_q[RECIP_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/mtfa_front.sv */
`default_nettype none

// Front part: configuration registers, slope reciprocals and bin classification.
module mtfa_front
	import mtfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FREQ_W-1:0]    cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [FREQ_W-1:0]    bin_freq,
	input  wire logic [POWER_W-1:0]   bin_power,
	input  wire logic                 last_bin,
	input  wire logic                 q_full,
	output logic                      q_push,
	output item_t                     q_item
);

	logic [FREQ_W-1:0]  low_q;
	logic [FREQ_W-1:0]  center_q;
	logic [FREQ_W-1:0]  high_q;
	logic [RECIP_W-1:0] recip_rise_q;
	logic [RECIP_W-1:0] recip_fall_q;
	logic               dirty_q;

	front_state_t state_q;
	front_state_t state_d;
	logic         clr_dirty;
	logic         load_rise;
	logic         load_fall;
	div_req_t     div_req;
	div_rsp_t     div_rsp;

	logic [FREQ_W-1:0] width_rise;
	logic [FREQ_W-1:0] width_fall;

	mtfa_recip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Slope widths, with a degenerate slope replaced by one hertz.
	always_comb begin
		width_rise = (center_q > low_q) ? (center_q - low_q) : ONE_HZ;
		width_fall = (high_q > center_q) ? (high_q - center_q) : ONE_HZ;
	end

	// Configuration writes; a write to the low, center or high register marks the reciprocals stale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			center_q <= '0;
			high_q   <= '0;
			dirty_q  <= 1'b0;
		end else begin
			if (clr_dirty) begin
				dirty_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LOW: begin
						low_q   <= cfg_wdata;
						dirty_q <= 1'b1;
					end
					REG_CENTER: begin
						center_q <= cfg_wdata;
						dirty_q  <= 1'b1;
					end
					REG_HIGH: begin
						high_q  <= cfg_wdata;
						dirty_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Reciprocal registers; the reset value matches widths of one hertz.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_rise_q <= RECIP_RST;
			recip_fall_q <= RECIP_RST;
		end else begin
			if (load_rise) begin
				recip_rise_q <= div_rsp.quotient;
			end
			if (load_fall) begin
				recip_fall_q <= div_rsp.quotient;
			end
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: recompute the rising, then the falling reciprocal.
	always_comb begin
		state_d       = state_q;
		clr_dirty     = 1'b0;
		load_rise     = 1'b0;
		load_fall     = 1'b0;
		div_req.start = 1'b0;
		div_req.width = width_rise;
		case (state_q)
			FS_IDLE: begin
				if (dirty_q) begin
					clr_dirty     = 1'b1;
					div_req.start = 1'b1;
					state_d       = FS_RISE;
				end
			end
			FS_RISE: begin
				if (div_rsp.done) begin
					load_rise     = 1'b1;
					div_req.start = 1'b1;
					div_req.width = width_fall;
					state_d       = FS_FALL;
				end
			end
			FS_FALL: begin
				if (div_rsp.done) begin
					load_fall = 1'b1;
					state_d   = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	// Accept a bin only with current reciprocals and room in the queue.
	assign in_stall = dirty_q || (state_q != FS_IDLE) || q_full;
	assign q_push   = in_valid && !in_stall;

	// Classify the bin: outside the band, rising slope or falling slope.
	always_comb begin
		q_item.power = bin_power;
		q_item.last  = last_bin;
		if ((bin_freq < low_q) || (bin_freq > high_q)) begin
			q_item.diff  = '0;
			q_item.recip = recip_rise_q;
		end else if (bin_freq < center_q) begin
			q_item.diff  = bin_freq - low_q;
			q_item.recip = recip_rise_q;
		end else begin
			q_item.diff  = high_q - bin_freq;
			q_item.recip = recip_fall_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/mtfa_queue.sv */
`default_nettype none

// Short FIFO of classified bins between the front and back parts.
module mtfa_queue
	import mtfa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output item_t      head_item
);

	item_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	assign full      = (count_q == Q_CW'(Q_DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* rtl/mtfa_back.sv */
`default_nettype none

// Back part: weight, weighted power, saturating accumulation and result register.
module mtfa_back
	import mtfa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire item_t      q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [OUT_W-1:0] band_power
);

	logic                advance;

	logic                valid_s1;
	logic [WPROD_W-1:0]  wprod_s1;
	logic [POWER_W-1:0]  power_s1;
	logic                last_s1;

	logic                valid_s2;
	logic [PPROD_W-1:0]  pprod_s2;
	logic                last_s2;

	logic [ACC_W-1:0]    acc_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    band_q;

	logic [WRAW_W-1:0]   weight_raw;
	logic [WEIGHT_W-1:0] weight;
	logic [PFULL_W-1:0]  pfull;
	logic [ACC_W:0]      sum_w;
	logic [ACC_W-1:0]    sum_sat;
	logic [WIDE_W-1:0]   sum_wide;

	// The whole back pipeline holds while a finished result waits.
	assign advance = !(out_valid_q && out_stall);
	assign q_pop   = advance && !q_empty;

	// Clamp the weight to 1.0 and scale the power.
	always_comb begin
		weight_raw = wprod_s1[WPROD_W-1:FRAC_W];
		weight     = (weight_raw > WRAW_W'(WEIGHT_ONE)) ? WEIGHT_ONE
		                                                : weight_raw[WEIGHT_W-1:0];
		pfull      = PFULL_W'(weight) * PFULL_W'(power_s1);
	end

	// Saturating add and output clamp.
	always_comb begin
		sum_w    = {1'b0, acc_q} + (ACC_W + 1)'(pprod_s2);
		sum_sat  = sum_w[ACC_W] ? {ACC_W{1'b1}} : sum_w[ACC_W-1:0];
		sum_wide = WIDE_W'(sum_sat);
	end

	// Stage valids, accumulator and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= q_pop;
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s2) begin
				acc_q <= last_s2 ? '0 : sum_sat;
			end
			if (advance && valid_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			wprod_s1 <= WPROD_W'(q_head.diff) * WPROD_W'(q_head.recip);
			power_s1 <= q_head.power;
			last_s1  <= q_head.last;
			pprod_s2 <= pfull[PFULL_W-1:FRAC_W];
			last_s2  <= last_s1;
			if (valid_s2 && last_s2) begin
				band_q <= (sum_wide > WIDE_W'(OUT_MAX)) ? OUT_MAX
				                                       : sum_wide[OUT_W-1:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign band_power = band_q;

endmodule

`default_nettype wire

/* rtl/mel_triangular_filter_accumulate.sv */
// Triangular filterbank band accumulator. Spectrum bins (frequency in 1/16 Hz,
// 32-bit power, last flag) enter on the in channel; each power is weighted by
// a triangle set by registers 0 (low edge), 1 (center) and 2 (high edge),
// added into a saturating accumulator, and on the last bin the band sum is
// sent on the out channel and the accumulator clears. Bins are taken at one
// per cycle while in_stall is low; a result goes through the queue, the weight
// and power product stages and the result register. A four-entry queue
// separates the classification front end from the two-multiplier back end, so
// the back end stalls only while a result waits on the out channel. Slope
// reciprocals come from a one-bit-per-cycle divider: in_stall rises with any
// write to registers 0 to 2 and stays high while both are recomputed. A write
// that lands during a recomputation starts another one, so a burst of writes
// can hold in_stall high through repeated recomputations. Reset values need no recomputation.
`default_nettype none

module mel_triangular_filter_accumulate
	import mtfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FREQ_W-1:0]    cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [FREQ_W-1:0]    bin_freq,
	input  wire logic [POWER_W-1:0]   bin_power,
	input  wire logic                 last_bin,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [OUT_W-1:0]          band_power
);

	logic  q_push;
	item_t q_push_item;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t q_head;

	// Front end: registers, reciprocals and classification.
	mtfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.bin_freq  (bin_freq),
		.bin_power (bin_power),
		.last_bin  (last_bin),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_push_item)
	);

	// Queue of classified bins.
	mtfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_item (q_head)
	);

	// Back end: weighting and accumulation.
	mtfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.band_power (band_power)
	);

endmodule

`default_nettype wire

/* tb/mel_triangular_filter_accumulate_test.sv */
`timescale 1ns / 100ps

module mel_triangular_filter_accumulate_test
	import mtfa_pkg::*;
();

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
	localparam logic [POWER_W-1:0] POWER_MAX = '1;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int FULL_BINS = 10;

	typedef struct {
		logic [FREQ_W-1:0] freq;
		logic [POWER_W-1:0] power;
		logic is_last;
	} bin_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FREQ_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FREQ_W-1:0] bin_freq = '0;
	logic [POWER_W-1:0] bin_power = '0;
	logic last_bin = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] band_power;

	// Predictor copy of the triangle corners and the running band sum.
	logic [FREQ_W-1:0] low_cfg = '0;
	logic [FREQ_W-1:0] center_cfg = '0;
	logic [FREQ_W-1:0] high_cfg = '0;
	logic [63:0] band_acc = '0;

	bin_item_t bin_queue[$];
	logic [OUT_W-1:0] band_expect[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_armed = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	mel_triangular_filter_accumulate u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bin_freq(bin_freq),
		.bin_power(bin_power),
		.last_bin(last_bin),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.band_power(band_power)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Slope reciprocal floor(2^32 / width); a width of zero or less becomes one hertz.
	function automatic logic [63:0] slope_recip(input logic [FREQ_W-1:0] hi,
			input logic [FREQ_W-1:0] lo);
		logic [63:0] width;
		width = (hi > lo) ? 64'(hi - lo) : 64'd16;
		return (64'd1 << 32) / width;
	endfunction

	// Triangle weight in Q1.16, clamped to 1.0.
	function automatic logic [63:0] bin_weight(input logic [FREQ_W-1:0] f);
		logic [63:0] diff;
		logic [63:0] recip;
		logic [63:0] w;
		if (f < low_cfg || f > high_cfg) begin
			return 64'd0;
		end
		if (f < center_cfg) begin
			diff = 64'(f - low_cfg);
			recip = slope_recip(center_cfg, low_cfg);
		end else begin
			diff = 64'(high_cfg - f);
			recip = slope_recip(high_cfg, center_cfg);
		end
		w = (diff * recip) >> 16;
		return (w > 64'd65536) ? 64'd65536 : w;
	endfunction

	// Adds one weighted bin to the band sum; a last bin yields the expected band power.
	function automatic void accumulate_bin(input logic [FREQ_W-1:0] f,
			input logic [POWER_W-1:0] p, input logic is_last);
		logic [63:0] lim;
		logic [63:0] prod;
		logic [63:0] sum;
		lim = {64{1'b1}} >> (64 - ACC_W);
		prod = (bin_weight(f) * 64'(p)) >> 16;
		if (band_acc > lim) begin
			band_acc = lim;
		end
		sum = (prod > lim - band_acc) ? lim : band_acc + prod;
		if (is_last) begin
			band_expect.push_back((sum > 64'(OUT_MAX)) ? OUT_MAX : sum[OUT_W-1:0]);
			band_acc = '0;
		end else begin
			band_acc = sum;
		end
	endfunction

	task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
		end
	endtask

	// Input driver: the predictor runs on each accepted transaction.
	always @(posedge clk) begin : bin_driver
		bin_item_t next_bin;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accumulate_bin(bin_freq, bin_power, last_bin);
			end
			if (!in_valid || !in_stall) begin
				if (bin_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_bin = bin_queue.pop_front();
					in_valid <= 1'b1;
					bin_freq <= next_bin.freq;
					bin_power <= next_bin.power;
					last_bin <= next_bin.is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random, plus one long hold-off when armed.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Output monitor: each result transaction is checked against the oldest expectation.
	always @(posedge clk) begin : band_monitor
		logic [OUT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (band_expect.size() == 0) begin
				note_mismatch("band_power with nothing pending", '0, band_power);
			end else begin
				want = band_expect.pop_front();
				if (band_power !== want) begin
					note_mismatch("band_power mismatch", want, band_power);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction or register write.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL mel_triangular_filter_accumulate");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_LOW: low_cfg = value;
			REG_CENTER: center_cfg = value;
			REG_HIGH: high_cfg = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_triangle(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] ce,
			input logic [FREQ_W-1:0] hi);
		write_reg(REG_LOW, lo);
		write_reg(REG_CENTER, ce);
		write_reg(REG_HIGH, hi);
	endtask

	task automatic push_bin(input logic [FREQ_W-1:0] f, input logic [POWER_W-1:0] p,
			input logic is_last);
		bin_item_t b;
		b.freq = f;
		b.power = p;
		b.is_last = is_last;
		bin_queue.push_back(b);
	endtask

	// Bin frequencies mostly fall inside the triangle, some on its corners.
	function automatic logic [FREQ_W-1:0] rand_bin_freq();
		case ($urandom_range(9))
			0, 1: return FREQ_W'($urandom);
			2: begin
				case ($urandom_range(6))
					0: return low_cfg;
					1: return low_cfg - 1'b1;
					2: return center_cfg;
					3: return center_cfg - 1'b1;
					4: return center_cfg + 1'b1;
					5: return high_cfg;
					default: return high_cfg + 1'b1;
				endcase
			end
			default: begin
				if (low_cfg <= high_cfg) begin
					return FREQ_W'($urandom_range(high_cfg, low_cfg));
				end
				return FREQ_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [POWER_W-1:0] rand_bin_power();
		case ($urandom_range(9))
			0: return '0;
			1: return POWER_MAX;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_random_bins(input int count);
		for (int i = 0; i < count; i++) begin
			push_bin(rand_bin_freq(), rand_bin_power(), $urandom_range(7) == 0);
		end
	endtask

	// Idle means no stimulus pending, nothing expected, and the pipeline drained.
	task automatic wait_idle();
		do @(negedge clk);
		while (bin_queue.size() != 0 || in_valid || band_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin : stimulus
		logic [FREQ_W-1:0] a;
		logic [FREQ_W-1:0] b;
		logic [FREQ_W-1:0] c;
		logic [FREQ_W-1:0] t;

		set_idle(38, 78);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// All corners at their reset value of zero.
		push_bin('0, POWER_MAX, 1'b0);
		push_bin(FREQ_MAX, POWER_MAX, 1'b0);
		push_bin('0, POWER_MAX, 1'b1);
		wait_idle();

		// Directed bins around every corner, field extremes and single-bin bands.
		set_triangle(20'd16000, 20'd32000, 20'd64000);
		push_bin('0, POWER_MAX, 1'b0);
		push_bin(20'd15999, POWER_MAX, 1'b0);
		push_bin(20'd16000, POWER_MAX, 1'b0);
		push_bin(20'd16001, POWER_MAX, 1'b0);
		push_bin(20'd24000, 32'h8000_0000, 1'b1);
		push_bin(20'd31999, POWER_MAX, 1'b0);
		push_bin(20'd32000, POWER_MAX, 1'b1);
		push_bin(20'd32000, '0, 1'b1);
		push_bin(20'd32001, 32'hAAAA_AAAA, 1'b0);
		push_bin(20'd48000, 32'h5555_5555, 1'b0);
		push_bin(20'd63999, POWER_MAX, 1'b0);
		push_bin(20'd64000, POWER_MAX, 1'b0);
		push_bin(20'd64001, POWER_MAX, 1'b0);
		push_bin(FREQ_MAX, POWER_MAX, 1'b1);
		push_bin(20'd32000, 32'd1, 1'b1);
		push_bin(20'd24000, 32'd1, 1'b0);
		push_bin(20'h55555, 32'h1234_5678, 1'b1);
		wait_idle();

		// Full-range rising slope with a degenerate falling slope.
		set_triangle('0, FREQ_MAX, FREQ_MAX);
		push_random_bins(80);
		wait_idle();

		// Center above the upper corner; a write to the unused index is ignored.
		set_triangle(20'd100, 20'd500, 20'd300);
		write_reg(REG_SPARE, 20'h5A5A5);
		push_random_bins(80);
		wait_idle();

		set_idle(78, 38);
		set_triangle(20'd1000, 20'd1008, 20'd1020);
		push_random_bins(80);
		wait_idle();

		// Narrow random triangle, slopes sometimes of zero width.
		a = FREQ_W'($urandom_range(1000000, 0));
		b = a + FREQ_W'($urandom_range(40));
		c = b + FREQ_W'($urandom_range(40));
		set_triangle(a, b, c);
		push_random_bins(80);
		wait_idle();

		// Center below the lower corner.
		set_triangle(20'd100, 20'd50, 20'd300);
		push_random_bins(60);
		wait_idle();

		set_idle(0, 0);
		set_triangle(FREQ_MAX, FREQ_MAX, FREQ_MAX);
		push_random_bins(40);
		wait_idle();

		// Wide random triangle; the receiver holds off long enough to back up the input.
		a = FREQ_W'($urandom);
		b = FREQ_W'($urandom);
		c = FREQ_W'($urandom);
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (b > c) begin
			t = b; b = c; c = t;
		end
		if (a > b) begin
			t = a; a = b; b = t;
		end
		set_triangle(a, b, c);
		hold_armed = 1'b1;
		push_random_bins(120);
		wait_idle();

		// A band of full-weight, full-power bins, then a one-bin band.
		set_triangle('0, 20'd1024, 20'd2048);
		for (int i = 0; i < FULL_BINS; i++) begin
			push_bin(20'd1024, POWER_MAX, i == FULL_BINS - 1);
		end
		push_bin(20'd1024, POWER_MAX, 1'b1);
		wait_idle();

		// Corners written back to zero.
		set_triangle('0, '0, '0);
		push_random_bins(30);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("PASS mel_triangular_filter_accumulate");
		end else begin
			$display("FAIL mel_triangular_filter_accumulate");
		end
		$finish;
	end

endmodule
